/* rtl/gdm_pkg.sv */
// Shared types and constants for the graph degree min/max block.
// Holds the request, result and internal command formats and the register map.
// Depends on nothing; gdm_front, gdm_back and the top module import it.
package gdm_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int Q_DEPTH          = 2;

  localparam int VTX_W = 6;
  localparam int DEG_W = 7;
  localparam int CNT_W = 7;
  localparam int NV_W  = 7;

  localparam logic [NV_W-1:0] NV_RESET = 7'd64;

  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_NUM_VERTICES = 2'd0;

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_ANALYSE = 2'd1,
    REQ_QUERY   = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_kind_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;
  } req_t;

  typedef struct packed {
    logic             status;
    logic [DEG_W-1:0] min_degree;
    logic [DEG_W-1:0] max_degree;
    logic [CNT_W-1:0] min_count;
    logic [CNT_W-1:0] max_count;
    logic [DEG_W-1:0] vertex_degree;
    logic             vertex_is_min;
    logic             vertex_is_max;
  } res_t;

  // classified request, as queued between front and back
  typedef struct packed {
    req_kind_t        kind;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
    logic             bad;
    logic [NV_W-1:0]  n;
  } cmd_t;

endpackage

/* rtl/gdm_fifo.sv */
// Small synchronous queue of fixed-width words.
// Used for the command queue and the result queue; no package dependency.
module gdm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

/* rtl/gdm_front.sv */
// Front end: configuration register and request classification.
// Clamps the vertex count, flags out-of-range vertices; uses gdm_pkg.
module gdm_front
  import gdm_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  req_t               request,
  output cmd_t               cmd
);

  logic [NV_W-1:0] num_vertices;
  logic [NV_W-1:0] n_use;
  req_kind_t       kind;
  logic            a_out;
  logic            b_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_vertices <= NV_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_NUM_VERTICES) begin
      num_vertices <= pwdata[NV_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_NUM_VERTICES) ? PDATA_W'(num_vertices) : '0;

  // zero acts as one vertex, anything above the array size as the array size
  always_comb begin
    priority if (num_vertices == '0) begin
      n_use = NV_W'(1);
    end else if (32'(num_vertices) > MAX_VERTICES) begin
      n_use = NV_W'(MAX_VERTICES);
    end else begin
      n_use = num_vertices;
    end
  end

  assign kind  = req_kind_t'(request.req_type);
  assign a_out = NV_W'(request.vertex_a) >= n_use;
  assign b_out = NV_W'(request.vertex_b) >= n_use;

  always_comb begin
    cmd.kind = kind;
    cmd.a    = request.vertex_a;
    cmd.b    = request.vertex_b;
    cmd.n    = n_use;
    unique case (kind)
      REQ_INSERT:  cmd.bad = a_out || b_out;
      REQ_QUERY:   cmd.bad = a_out;
      REQ_ANALYSE: cmd.bad = 1'b0;
      REQ_CLEAR:   cmd.bad = 1'b0;
      default:     cmd.bad = 1'b0;
    endcase
  end

endmodule

/* rtl/gdm_back.sv */
// Back end: adjacency and degree memories with the sequencer that runs
// inserts, queries, clears and the degree scan; uses gdm_pkg.
module gdm_back
  import gdm_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_empty,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  // only vertices 0..63 can ever be named, so nothing above them is stored
  localparam int DEPTH = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_RD     = 9'b000000010,
    S_EDGE_A = 9'b000000100,
    S_EDGE_B = 9'b000001000,
    S_QUERY  = 9'b000010000,
    S_SCAN   = 9'b000100000,
    S_DRAIN  = 9'b001000000,
    S_AFIN   = 9'b010000000,
    S_PUSH   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  cmd_t   cur;

  logic [DEPTH-1:0] row_mem [DEPTH];
  logic [DEG_W-1:0] deg_mem [DEPTH];
  logic [DEPTH-1:0] vld;

  logic [NV_W-1:0]  rd0_idx;
  logic             rd0_in;
  logic [AW-1:0]    rd0_addr;
  logic [AW-1:0]    rd1_addr;
  logic [DEPTH-1:0] row_rd0;
  logic [DEPTH-1:0] row_rd1;
  logic [DEG_W-1:0] deg_rd0;
  logic [DEG_W-1:0] deg_rd1;
  logic             ok0;
  logic             ok1;
  logic [DEPTH-1:0] row0;
  logic [DEPTH-1:0] row1;
  logic [DEG_W-1:0] deg0;
  logic [DEG_W-1:0] deg1;
  logic [DEPTH-1:0] bit_a;
  logic [DEPTH-1:0] bit_b;
  logic             edge_exists;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [DEPTH-1:0] wr_row;
  logic [DEG_W-1:0] wr_deg;

  logic [NV_W-1:0]  scan_idx;
  logic             pend;
  logic             first;
  logic [DEG_W-1:0] lo;
  logic [DEG_W-1:0] hi;
  logic [CNT_W-1:0] clo;
  logic [CNT_W-1:0] chi;
  logic [DEG_W-1:0] last_min;
  logic [DEG_W-1:0] last_max;
  res_t             res_q;
  res_t             res_init;

  assign rd0_idx  = (state == S_SCAN) ? scan_idx : NV_W'(cur.a);
  assign rd0_in   = 32'(rd0_idx) < DEPTH;
  assign rd0_addr = rd0_idx[AW-1:0];
  assign rd1_addr = cur.b[AW-1:0];

  // entries never written since reset or clear read as zero
  assign row0 = ok0 ? row_rd0 : '0;
  assign row1 = ok1 ? row_rd1 : '0;
  assign deg0 = ok0 ? deg_rd0 : '0;
  assign deg1 = ok1 ? deg_rd1 : '0;

  assign bit_a       = DEPTH'(1) << cur.a[AW-1:0];
  assign bit_b       = DEPTH'(1) << cur.b[AW-1:0];
  assign edge_exists = row0[cur.b[AW-1:0]];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[wr_addr] <= wr_row;
      deg_mem[wr_addr] <= wr_deg;
    end
    row_rd0 <= row_mem[rd0_addr];
    row_rd1 <= row_mem[rd1_addr];
    deg_rd0 <= deg_mem[rd0_addr];
    deg_rd1 <= deg_mem[rd1_addr];
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = cur.a[AW-1:0];
    wr_row     = row0 | bit_b;
    wr_deg     = deg0 + DEG_W'(1);
    unique case (state)
      S_IDLE: begin
        // start only with room for the result, so the back never blocks at the end
        if (!cmd_empty && !res_full) begin
          cmd_pop    = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        priority if (cur.bad) begin
          state_next = S_PUSH;
        end else begin
          unique case (cur.kind)
            REQ_INSERT:  state_next = S_EDGE_A;
            REQ_QUERY:   state_next = S_QUERY;
            REQ_ANALYSE: state_next = S_SCAN;
            REQ_CLEAR:   state_next = S_PUSH;
            default:     state_next = S_PUSH;
          endcase
        end
      end
      S_EDGE_A: begin
        if (edge_exists) begin
          state_next = S_PUSH;
        end else begin
          wr_en      = 1'b1;
          state_next = (cur.a == cur.b) ? S_PUSH : S_EDGE_B;
        end
      end
      S_EDGE_B: begin
        wr_en      = 1'b1;
        wr_addr    = cur.b[AW-1:0];
        wr_row     = row1 | bit_a;
        wr_deg     = deg1 + DEG_W'(1);
        state_next = S_PUSH;
      end
      S_QUERY: state_next = S_PUSH;
      S_SCAN: begin
        if (scan_idx == cur.n - NV_W'(1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_AFIN;
      S_AFIN:  state_next = S_PUSH;
      S_PUSH: begin
        res_push   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      vld      <= '0;
      ok0      <= 1'b0;
      ok1      <= 1'b0;
      pend     <= 1'b0;
      first    <= 1'b0;
      scan_idx <= '0;
      last_min <= '0;
      last_max <= '0;
    end else begin
      state <= state_next;
      ok0   <= rd0_in && vld[rd0_addr];
      ok1   <= vld[rd1_addr];
      pend  <= (state == S_SCAN);
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (state == S_RD && !cur.bad && cur.kind == REQ_CLEAR) begin
        vld <= '0;
      end
      if (state == S_RD) begin
        scan_idx <= '0;
        first    <= 1'b1;
      end else if (state == S_SCAN) begin
        scan_idx <= scan_idx + NV_W'(1);
      end
      if (pend) begin
        first <= 1'b0;
      end
      if (state == S_AFIN) begin
        last_min <= lo;
        last_max <= hi;
      end
    end
  end

  // fresh result: status only, every other field zero
  always_comb begin
    res_init        = '0;
    res_init.status = cur.bad;
  end

  // command capture, running extremes and their counts (one degree per cycle), result fields
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (pend) begin
      if (first) begin
        lo  <= deg0;
        hi  <= deg0;
        clo <= CNT_W'(1);
        chi <= CNT_W'(1);
      end else begin
        if (deg0 < lo) begin
          lo  <= deg0;
          clo <= CNT_W'(1);
        end else if (deg0 == lo) begin
          clo <= clo + CNT_W'(1);
        end
        if (deg0 > hi) begin
          hi  <= deg0;
          chi <= CNT_W'(1);
        end else if (deg0 == hi) begin
          chi <= chi + CNT_W'(1);
        end
      end
    end
    if (state == S_RD) begin
      res_q <= res_init;
    end else if (state == S_QUERY) begin
      res_q.vertex_degree <= deg0;
      res_q.vertex_is_min <= (deg0 == last_min);
      res_q.vertex_is_max <= (deg0 == last_max);
    end else if (state == S_AFIN) begin
      res_q.min_count <= clo;
      res_q.max_count <= chi;
    end
  end

  always_comb begin
    res            = res_q;
    res.min_degree = last_min;
    res.max_degree = last_max;
  end

endmodule

/* rtl/graph_degree_min_max_top.sv */
// Graph degree min/max tracker: adjacency bit matrix plus per-vertex degrees.
// Channels: requests enter through push/full (queue write side), results
// leave through empty/pop (queue read side); one result per request, in order.
// num_vertices sits at byte address 0 of the APB port; write it only while
// no request is outstanding.
// Each accepted request is popped into the back end, which reads its rows and
// degrees; clear and rejected requests then go straight to the result, inserts
// of a new edge write vertex a and, between two vertices, vertex b, queries
// capture the degree, and analyse scans the n vertices in use, then drains.
// The degree scan reads one entry of the degree memory per cycle. Requests run
// one at a time in the back end, which takes the next after pushing a result.
// A two-entry command queue keeps taking requests while a long scan runs, and
// a two-entry result queue holds finished results while the receiver stalls;
// the back end starts a request only when the result queue has room.
// Reset (rst, synchronous) empties both queues, marks every vertex row and
// degree as zero through per-vertex valid bits, zeroes the stored extremes
// and sets num_vertices to 64. A clear request drops the valid bits at once.
// Depends on gdm_pkg, gdm_front, gdm_fifo and gdm_back.
module graph_degree_min_max_top
  import gdm_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int QUEUE_DEPTH  = Q_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  req_t               request,
  output logic               empty,
  input  logic               pop,
  output res_t               result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  cmd_t             cmd_in;
  cmd_t             cmd_out;
  logic [CMD_W-1:0] cmd_in_w;
  logic [CMD_W-1:0] cmd_out_w;
  logic             cmd_empty;
  logic             cmd_pop;
  res_t             res_in;
  logic [RES_W-1:0] res_in_w;
  logic [RES_W-1:0] res_out_w;
  logic             res_full;
  logic             res_push;

  gdm_front #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .request (request),
    .cmd     (cmd_in)
  );

  assign cmd_in_w = cmd_in;
  assign cmd_out  = cmd_t'(cmd_out_w);

  gdm_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .din   (cmd_in_w),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .dout  (cmd_out_w)
  );

  gdm_back #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  assign res_in_w = res_in;
  assign result   = res_t'(res_out_w);

  gdm_fifo #(
    .WIDTH(RES_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .din   (res_in_w),
    .pop   (pop),
    .empty (empty),
    .dout  (res_out_w)
  );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for graph_degree_min_max_top: directed and random
// insert/analyse/query/clear requests checked against a local graph predictor.
// Depends on gdm_pkg and the RTL in rtl; num_vertices is reprogrammed over APB.
module tb_top;
  import gdm_pkg::*;

  localparam int NV_MAX         = 64;
  localparam int IDLE_PCT       = 31;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int NUM_PHASES     = 11;
  localparam int PHASE_ITEMS    = 66;
  localparam int QUIET_PHASE    = 7;

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               push    = 1'b0;
  req_t               request = '0;
  logic               pop     = 1'b0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic               full;
  logic               empty;
  logic               pready;
  res_t               result;
  logic [PDATA_W-1:0] prdata;

  graph_degree_min_max_top u_top (.*);

  // graph shadow
  logic [NV_MAX-1:0] adj_rows   [NV_MAX];
  logic [DEG_W-1:0]  vtx_degree [NV_MAX];
  logic [DEG_W-1:0]  seen_min;
  logic [DEG_W-1:0]  seen_max;
  logic [NV_W-1:0]   nv_reg;

  logic [NV_W-1:0] phase_nv [NUM_PHASES];
  req_t item_queue[$];
  res_t expected_results[$];

  int errors        = 0;
  int items_sent    = 0;
  int analyses_sent = 0;
  int results_seen  = 0;
  int rejects_seen  = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  bit hold_done     = 1'b0;
  bit gaps_on       = 1'b1;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int active_n();
    if (nv_reg == '0) return 1;
    if (int'(nv_reg) > NV_MAX) return NV_MAX;
    return int'(nv_reg);
  endfunction

  function automatic void clear_graph();
    for (int v = 0; v < NV_MAX; v++) begin
      adj_rows[v]   = '0;
      vtx_degree[v] = '0;
    end
  endfunction

  // Update the shadow graph with one request and return the result it yields.
  function automatic res_t apply_request(req_t r);
    res_t             o;
    int               n;
    logic [DEG_W-1:0] lo;
    logic [DEG_W-1:0] hi;
    logic [CNT_W-1:0] n_lo;
    logic [CNT_W-1:0] n_hi;
    o = '0;
    n = active_n();
    case (req_kind_t'(r.req_type))
      REQ_INSERT: begin
        if (int'(r.vertex_a) >= n || int'(r.vertex_b) >= n) begin
          o.status = 1'b1;
        end else if (!adj_rows[r.vertex_a][r.vertex_b]) begin
          adj_rows[r.vertex_a][r.vertex_b] = 1'b1;
          adj_rows[r.vertex_b][r.vertex_a] = 1'b1;
          vtx_degree[r.vertex_a] = vtx_degree[r.vertex_a] + DEG_W'(1);
          // a self-loop counts once
          if (r.vertex_a != r.vertex_b)
            vtx_degree[r.vertex_b] = vtx_degree[r.vertex_b] + DEG_W'(1);
        end
      end
      REQ_ANALYSE: begin
        lo   = vtx_degree[0];
        hi   = vtx_degree[0];
        n_lo = '0;
        n_hi = '0;
        for (int v = 1; v < n; v++) begin
          if (vtx_degree[v] < lo) lo = vtx_degree[v];
          if (vtx_degree[v] > hi) hi = vtx_degree[v];
        end
        for (int v = 0; v < n; v++) begin
          if (vtx_degree[v] == lo) n_lo++;
          if (vtx_degree[v] == hi) n_hi++;
        end
        seen_min    = lo;
        seen_max    = hi;
        o.min_count = n_lo;
        o.max_count = n_hi;
      end
      REQ_QUERY: begin
        if (int'(r.vertex_a) >= n) begin
          o.status = 1'b1;
        end else begin
          o.vertex_degree = vtx_degree[r.vertex_a];
          o.vertex_is_min = (vtx_degree[r.vertex_a] == seen_min);
          o.vertex_is_max = (vtx_degree[r.vertex_a] == seen_max);
        end
      end
      REQ_CLEAR: clear_graph();
    endcase
    o.min_degree = seen_min;
    o.max_degree = seen_max;
    return o;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result(res_t got, res_t want);
    check_field("status", 8'(want.status), 8'(got.status));
    check_field("min_degree", 8'(want.min_degree), 8'(got.min_degree));
    check_field("max_degree", 8'(want.max_degree), 8'(got.max_degree));
    check_field("min_count", 8'(want.min_count), 8'(got.min_count));
    check_field("max_count", 8'(want.max_count), 8'(got.max_count));
    check_field("vertex_degree", 8'(want.vertex_degree), 8'(got.vertex_degree));
    check_field("vertex_is_min", 8'(want.vertex_is_min), 8'(got.vertex_is_min));
    check_field("vertex_is_max", 8'(want.vertex_is_max), 8'(got.vertex_is_max));
  endtask

  function automatic void add_item(req_kind_t kind, int a, int b);
    req_t r;
    r.req_type = kind;
    r.vertex_a = a[VTX_W-1:0];
    r.vertex_b = b[VTX_W-1:0];
    item_queue.push_back(r);
  endfunction

  // Mostly in-range inserts, some on a hub; other kinds and out-of-range noise too.
  function automatic req_t random_item(int n, int hub);
    req_t r;
    int   roll;
    roll = $urandom_range(99);
    r.vertex_a = VTX_W'($urandom_range(NV_MAX - 1));
    r.vertex_b = VTX_W'($urandom_range(NV_MAX - 1));
    if (roll < 3) begin
      r.req_type = REQ_CLEAR;
    end else if (roll < 18) begin
      r.req_type = REQ_ANALYSE;
    end else if (roll < 38) begin
      r.req_type = REQ_QUERY;
      if ($urandom_range(99) < 85) r.vertex_a = VTX_W'($urandom_range(n - 1));
    end else begin
      r.req_type = REQ_INSERT;
      if ($urandom_range(99) < 85) begin
        r.vertex_a = ($urandom_range(3) == 0) ? VTX_W'(hub) : VTX_W'($urandom_range(n - 1));
        r.vertex_b = ($urandom_range(11) == 0) ? r.vertex_a : VTX_W'($urandom_range(n - 1));
      end
    end
    return r;
  endfunction

  task automatic apb_access(input logic write, input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= ADDR_NUM_VERTICES;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_vertex_count(input logic [NV_W-1:0] value);
    logic [PDATA_W-1:0] wdata;
    logic [PDATA_W-1:0] rdata;
    wdata = $urandom;
    wdata[NV_W-1:0] = value;
    apb_access(1'b1, wdata, rdata);
    nv_reg = value;
    apb_access(1'b0, '0, rdata);
    if (rdata[NV_W-1:0] !== value) begin
      errors++;
      $display("%0t: num_vertices readback mismatch: expected %0d, got %0d",
               $time, value, rdata[NV_W-1:0]);
    end
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (item_queue.size() != 0 || push || expected_results.size() != 0);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_results.push_back(apply_request(request));
        items_sent++;
        if (request.req_type == REQ_ANALYSE) analyses_sent++;
      end
      if (!push || !full) begin
        if (item_queue.size() != 0 && !(gaps_on && $urandom_range(99) < IDLE_PCT)) begin
          request <= item_queue.pop_front();
          push    <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: expected none, got %p", $time, result);
        end else begin
          check_result(result, expected_results.pop_front());
        end
        results_seen++;
        if (result.status) rejects_seen++;
      end
      // hold off once for a long stretch so the block backs up into full
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop       <= 1'b0;
      end else if (!hold_done && results_seen >= 100 && item_queue.size() >= 20) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        pop       <= 1'b0;
      end else begin
        pop <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired after %0d cycles without progress", $time, quiet_cycles);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n;
    int hub;
    clear_graph();
    seen_min = '0;
    seen_max = '0;
    nv_reg   = NV_RESET;
    phase_nv = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd5, 7'd13, 7'd33, 7'd64, 7'd100, 7'd8, 7'd64};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // query before any analyse, empty-graph analyse, duplicates, self-loops, clear
    add_item(REQ_QUERY, 0, 0);
    add_item(REQ_ANALYSE, 0, 0);
    add_item(REQ_INSERT, 0, 63);
    add_item(REQ_INSERT, 63, 0);
    add_item(REQ_INSERT, 5, 5);
    add_item(REQ_INSERT, 5, 5);
    add_item(REQ_INSERT, 63, 63);
    add_item(REQ_INSERT, 0, 1);
    add_item(REQ_INSERT, 42, 21);
    add_item(REQ_QUERY, 63, 0);
    add_item(REQ_QUERY, 5, 0);
    add_item(REQ_ANALYSE, 0, 0);
    add_item(REQ_QUERY, 0, 0);
    add_item(REQ_QUERY, 10, 0);
    add_item(REQ_CLEAR, 0, 0);
    add_item(REQ_QUERY, 5, 0);
    add_item(REQ_INSERT, 63, 62);
    add_item(REQ_ANALYSE, 0, 0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      set_vertex_count(phase_nv[p]);
      if (p == 0) begin
        // single vertex: out-of-range ends and a graph where every vertex self-loops
        add_item(REQ_INSERT, 0, 1);
        add_item(REQ_INSERT, 1, 0);
        add_item(REQ_QUERY, 1, 0);
        add_item(REQ_INSERT, 0, 0);
        add_item(REQ_QUERY, 0, 0);
        add_item(REQ_ANALYSE, 0, 0);
        add_item(REQ_QUERY, 63, 0);
        add_item(REQ_INSERT, 63, 63);
      end
      gaps_on <= (p != QUIET_PHASE);
      n   = active_n();
      hub = $urandom_range(n - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) item_queue.push_back(random_item(n, hub));
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests (%0d analyses) over %0d vertex-count settings.",
             items_sent, analyses_sent, NUM_PHASES);
    $display("Checked %0d results, %0d of them out-of-range rejects.", results_seen, rejects_seen);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
